/* hdl/bcdly_pkg.sv */
// Shared types, constants and the phase delay table of the contention delay block.
package bcdly_pkg;

	// Bus cycle kinds
	localparam logic [2:0] KIND_FETCH     = 3'd0;
	localparam logic [2:0] KIND_MEM_READ  = 3'd1;
	localparam logic [2:0] KIND_MEM_WRITE = 3'd2;
	localparam logic [2:0] KIND_IO_READ   = 3'd3;
	localparam logic [2:0] KIND_IO_WRITE  = 3'd4;

	// Frame timing in T-states
	localparam int FrameTstates    = 69888;
	localparam int ContendedStart  = 14335;
	localparam int LineTstates     = 224;
	localparam int DisplayTstates  = 128;
	localparam int DisplayLines    = 192;
	localparam int DisplayEnd      = ContendedStart + DisplayLines * LineTstates;

	// Frame is 256 x 273 T-states, a line 32 x 7
	localparam int FrameHiDivisor  = FrameTstates / 256;
	localparam int LineHiDivisor   = LineTstates / 32;

	typedef logic [16:0] frame_t;   // T-state within frame, below 69888
	typedef logic [7:0]  col_t;     // T-state within display line, below 224
	typedef logic [2:0]  delay_t;   // per T-state delay, at most 6
	typedef logic [23:0] mul_op_t;  // shared multiplier operand
	typedef logic [47:0] prod_t;    // shared multiplier product
	typedef logic [8:0]  mod_rem_t; // remainder of the high part, below 273

	localparam frame_t FRAME_LAST      = frame_t'(FrameTstates - 1);
	localparam frame_t CONT_START      = frame_t'(ContendedStart);
	localparam frame_t CONT_END        = frame_t'(DisplayEnd);
	localparam col_t   COL_LAST        = col_t'(LineTstates - 1);
	localparam col_t   COL_DISPLAY     = col_t'(DisplayTstates);

	// divisors of the high parts and their reciprocals, floor(2^32 / 273) and
	// floor(2^16 / 7); either estimate is at most one below the true quotient
	localparam mod_rem_t FRAME_DIVISOR = mod_rem_t'(FrameHiDivisor);
	localparam mod_rem_t LINE_DIVISOR  = mod_rem_t'(LineHiDivisor);
	localparam mul_op_t  RECIP_FRAME   = mul_op_t'(15732480);
	localparam mul_op_t  RECIP_LINE    = mul_op_t'(9362);

	// Beam position handed to the delay lookup
	typedef struct packed {
		frame_t frame;
		col_t   col;
	} beam_pos_t;

	// Delay by phase within the eight T-state fetch group
	function automatic delay_t phase_delay(input logic [2:0] phase);
		delay_t d;
		unique case (phase)
			3'd0: d = 3'd6;
			3'd1: d = 3'd5;
			3'd2: d = 3'd4;
			3'd3: d = 3'd3;
			3'd4: d = 3'd2;
			3'd5: d = 3'd1;
			default: d = 3'd0;
		endcase
		return d;
	endfunction

endpackage

/* hdl/bcdly_mod_step.sv */
// Shared reduction unit: one multiplier and the remainder fix-up of a reciprocal modulo.
module bcdly_mod_step
	import bcdly_pkg::*;
(
	input  mul_op_t  mul_a,
	input  mul_op_t  mul_b,
	output prod_t    prod,
	input  mul_op_t  num,
	input  mul_op_t  qd,
	input  mod_rem_t divisor,
	output mod_rem_t rem
);

	mul_op_t diff;
	mul_op_t fixed;

	// quotient estimate and back-multiply both go through this product
	assign prod = mul_a * mul_b;

	// estimate is at most one low, so one subtract of the divisor suffices
	assign diff  = num - qd;
	assign fixed = diff - {15'd0, divisor};
	assign rem   = (diff >= {15'd0, divisor}) ? fixed[8:0] : diff[8:0];

endmodule

/* hdl/bcdly_delay.sv */
// Contention delay of one T-state from its frame position and line column.
module bcdly_delay
	import bcdly_pkg::*;
(
	input  beam_pos_t pos,
	output delay_t    delay
);

	logic       in_window;
	logic [2:0] phase;

	// inside the display window: contended lines and the pixel part of the line
	assign in_window = (pos.frame >= CONT_START) && (pos.frame < CONT_END) &&
		(pos.col < COL_DISPLAY);

	// (frame - 14335) mod 8 == frame + 1 mod 8
	assign phase = pos.frame[2:0] + 3'd1;

	assign delay = in_window ? phase_delay(phase) : 3'd0;

endmodule

/* hdl/bus_contention_delay.sv */
// Top level of the bus contention delay block: sequencer, shared multiplier unit, output register.
//
// Each request describes one bus cycle (kind, address, master tick, length in
// T-states) and yields one result, the wait states the video chip inserts.
// Both channels use valid/ready; a request is taken when in_valid and in_ready
// are high together, a result when out_valid and out_ready are.
// A contended request first reduces the T-state (tick / 2) modulo the frame
// length through the shared multiplier: reciprocal estimate, back-multiply,
// subtract and fix-up, then reduces the display offset modulo the line length
// the same way, then walks the cycle's T-states one a cycle (1 for memory,
// cycle_length for I/O). Requests that need no lookup (uncontended address,
// odd port, zero-length I/O, disabled) go straight to the final state.
// One request is worked on at a time; in_ready is high only when the
// sequencer is idle. The result sits in an output register, so a stalled
// receiver holds the block in its final state until the register frees up.
// Reset clears the sequencer and the output valid and sets contention
// enabled; cfg_we writes the enable bit.
module bus_contention_delay
	import bcdly_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cycle_kind,
	input  logic [15:0] bus_address,
	input  logic [63:0] tick_count,
	input  logic [7:0]  cycle_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  wait_states
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MODF = 3'd1;
	localparam logic [2:0] ST_MODL = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]  state_q;
	logic [1:0]  cnt_q;
	logic        enabled_q;
	logic        out_valid_q;
	logic [7:0]  wait_q;
	logic [31:0] tstate_q;
	prod_t       prod_q;
	frame_t      frame_q;
	col_t        col_q;
	logic [7:0]  len_q;
	logic [7:0]  idx_q;
	logic        skip_q;
	logic [7:0]  sum_q;

	logic        accept;
	logic        is_mem;
	logic        is_io;
	logic        low_page;
	logic        go;
	mul_op_t     mul_a;
	mul_op_t     mul_b;
	prod_t       prod;
	mul_op_t     num;
	mul_op_t     qd;
	mod_rem_t    divisor;
	mod_rem_t    red_rem;
	frame_t      off;
	logic [10:0] line_hi;
	beam_pos_t   pos;
	delay_t      delay;
	frame_t      frame_next;
	col_t        col_next;
	logic        out_free;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign wait_states = wait_q;
	assign out_free    = !out_valid_q || out_ready;

	// request decode
	assign is_mem   = (cycle_kind == KIND_FETCH) || (cycle_kind == KIND_MEM_READ) ||
		(cycle_kind == KIND_MEM_WRITE);
	assign is_io    = (cycle_kind == KIND_IO_READ) || (cycle_kind == KIND_IO_WRITE);
	assign low_page = (bus_address[15:14] == 2'b01);
	assign go       = enabled_q && ((is_mem && low_page) ||
		(is_io && !bus_address[0] && (cycle_length != 8'd0)));

	// display offset; garbage before the window, where the column is unused
	assign off     = frame_q - CONT_START;
	assign line_hi = off[15:5];

	// shared unit operands: step 0 estimates the quotient, step 1 multiplies it back
	always_comb begin
		if (state_q == ST_MODF) begin
			num     = tstate_q[31:8];
			divisor = FRAME_DIVISOR;
			if (cnt_q == 2'd0) begin
				mul_a = tstate_q[31:8];
				mul_b = RECIP_FRAME;
			end else begin
				mul_a = {8'd0, prod_q[47:32]};
				mul_b = {15'd0, FRAME_DIVISOR};
			end
		end else begin
			num     = {13'd0, line_hi};
			divisor = LINE_DIVISOR;
			if (cnt_q == 2'd0) begin
				mul_a = {13'd0, line_hi};
				mul_b = RECIP_LINE;
			end else begin
				mul_a = {8'd0, prod_q[31:16]};
				mul_b = {15'd0, LINE_DIVISOR};
			end
		end
	end

	assign qd = prod_q[23:0];

	bcdly_mod_step u_step (
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.prod    (prod),
		.num     (num),
		.qd      (qd),
		.divisor (divisor),
		.rem     (red_rem)
	);

	// delay lookup at the current beam position
	assign pos.frame = frame_q;
	assign pos.col   = col_q;

	bcdly_delay u_delay (
		.pos   (pos),
		.delay (delay)
	);

	// next beam position; the 32-bit T-state wrap restarts the frame
	always_comb begin
		if (tstate_q == 32'hffff_ffff || frame_q == FRAME_LAST) begin
			frame_next = '0;
		end else begin
			frame_next = frame_q + frame_t'(1);
		end
		if (frame_next == CONT_START || col_q == COL_LAST) begin
			col_next = '0;
		end else begin
			col_next = col_q + col_t'(1);
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			enabled_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				enabled_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= go ? ST_MODF : ST_DONE;
					end
				end
				ST_MODF: begin
					if (cnt_q == 2'd2) begin
						cnt_q   <= '0;
						state_q <= ST_MODL;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_MODL: begin
					if (cnt_q == 2'd2) begin
						cnt_q   <= '0;
						state_q <= ST_ACC;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_ACC: begin
					if (idx_q == len_q - 8'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tstate_q <= tick_count[32:1];
					len_q    <= is_mem ? 8'd1 : cycle_length;
					skip_q   <= is_io && !low_page;
					idx_q    <= '0;
					sum_q    <= '0;
				end
			end
			ST_MODF: begin
				if (cnt_q == 2'd2) begin
					frame_q <= {red_rem, tstate_q[7:0]};
				end else begin
					prod_q <= prod;
				end
			end
			ST_MODL: begin
				if (cnt_q == 2'd2) begin
					col_q <= {red_rem[2:0], off[4:0]};
				end else begin
					prod_q <= prod;
				end
			end
			ST_ACC: begin
				if (!(idx_q == 8'd0 && skip_q)) begin
					sum_q <= sum_q + {5'd0, delay};
				end
				tstate_q <= tstate_q + 32'd1;
				frame_q  <= frame_next;
				col_q    <= col_next;
				idx_q    <= idx_q + 8'd1;
			end
			ST_DONE: begin
				if (out_free) begin
					wait_q <= sum_q;
				end
			end
			default: begin
				sum_q <= '0;
			end
		endcase
	end

	// a taken request always leaves the idle state
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// the T-state walk never runs past the cycle length
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (idx_q < len_q))
		else $error("T-state walk past cycle length");

	// beam position stays inside frame and line during the walk
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> ((frame_q <= FRAME_LAST) && (col_q <= COL_LAST)))
		else $error("beam position out of range");

	// a result is only raised from the final state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside final state");

endmodule
